[hdl/cosol_pkg.sv]
// shared types, codes and defaults for the count-ordered self-organizing list
package cosol_pkg;

  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam int KEY_WIDTH   = 32;
  localparam int FUNC_WIDTH  = 2;
  localparam int HITS_WIDTH  = 16;

  localparam logic [FUNC_WIDTH-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_WIDTH-1:0] FN_DELETE = 2'd1;
  localparam logic [FUNC_WIDTH-1:0] FN_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_ORDER,
    S_SHDN,
    S_SHUP,
    S_PLACE
  } state_t;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_FIND,
    LD_ORDER,
    LD_SHDN,
    LD_SHUP
  } ld_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INSERT,
    WR_COUNT,
    WR_SHDN,
    WR_SHUP,
    WR_PLACE
  } wr_sel_t;

  typedef struct packed {
    logic    capture;
    ld_sel_t load;
    wr_sel_t wr;
    logic    latch_pos;
    logic    latch_j;
    logic    occ_inc;
    logic    occ_dec;
    logic    report;
    status_t rep_status;
    logic    rep_count;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
    logic find_hit;
    logic order_hit;
    logic drained;
  } dp_stat_t;

endpackage

[hdl/cosol_ctrl.sv]
// controller state machine: sequences find, reorder and shift steps
module cosol_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          func,
  input  cosol_pkg::dp_stat_t stat,
  output logic                busy,
  output cosol_pkg::ctl_cmd_t cmd
);
  import cosol_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [FUNC_WIDTH-1:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op <= func;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (op == FN_DELETE || op == FN_SEARCH) begin
          state_next = S_FIND;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIND: begin
        if (stat.find_hit) begin
          state_next = (op == FN_SEARCH) ? S_ORDER : S_SHUP;
        end else if (stat.drained) begin
          state_next = S_IDLE;
        end
      end
      S_ORDER: begin
        if (stat.order_hit) begin
          state_next = S_SHDN;
        end else if (stat.drained) begin
          state_next = S_IDLE;
        end
      end
      S_SHDN: begin
        if (stat.drained) begin
          state_next = S_PLACE;
        end
      end
      S_SHUP: begin
        if (stat.drained) begin
          state_next = S_IDLE;
        end
      end
      S_PLACE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load       = LD_NONE;
    cmd.wr         = WR_NONE;
    cmd.rep_status = ST_OK;
    busy           = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.capture = start;
      end
      S_DISPATCH: begin
        if (op == FN_INSERT) begin
          cmd.report = 1'b1;
          if (stat.full) begin
            cmd.rep_status = ST_FULL;
          end else begin
            cmd.wr      = WR_INSERT;
            cmd.occ_inc = 1'b1;
          end
        end else if (op == FN_DELETE || op == FN_SEARCH) begin
          cmd.load = LD_FIND;
        end else begin
          cmd.report     = 1'b1;
          cmd.rep_status = ST_NOT_FOUND;
        end
      end
      S_FIND: begin
        if (stat.find_hit) begin
          cmd.latch_pos = 1'b1;
          if (op == FN_SEARCH) begin
            cmd.wr   = WR_COUNT;
            cmd.load = LD_ORDER;
          end else begin
            cmd.load = LD_SHUP;
          end
        end else if (stat.drained) begin
          cmd.report     = 1'b1;
          cmd.rep_status = ST_NOT_FOUND;
        end
      end
      S_ORDER: begin
        if (stat.order_hit) begin
          cmd.latch_j = 1'b1;
          cmd.load    = LD_SHDN;
        end else if (stat.drained) begin
          // no entry ahead to pass: count already written in place
          cmd.report    = 1'b1;
          cmd.rep_count = 1'b1;
        end
      end
      S_SHDN: begin
        cmd.wr = WR_SHDN;
      end
      S_SHUP: begin
        cmd.wr = WR_SHUP;
        if (stat.drained) begin
          cmd.occ_dec = 1'b1;
          cmd.report  = 1'b1;
        end
      end
      S_PLACE: begin
        cmd.wr        = WR_PLACE;
        cmd.report    = 1'b1;
        cmd.rep_count = 1'b1;
      end
      default: begin
        cmd.wr = WR_NONE;
      end
    endcase
  end

endmodule

[hdl/cosol_dp.sv]
// datapath: entry memories, scan stream, occupancy and result registers
module cosol_dp #(
  parameter int CAPACITY    = cosol_pkg::DEF_CAPACITY,
  parameter int COUNT_WIDTH = cosol_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cosol_pkg::ctl_cmd_t                    cmd,
  input  logic signed [cosol_pkg::KEY_WIDTH-1:0] key_value,
  output cosol_pkg::dp_stat_t                    stat,
  output logic                                   done,
  output logic [1:0]                             status,
  output logic [cosol_pkg::HITS_WIDTH-1:0]       hit_count
);
  import cosol_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);

  logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
  logic [COUNT_WIDTH-1:0] cnt_mem [CAPACITY];

  logic [KEY_WIDTH-1:0]   key_reg;
  logic [OW-1:0]          occ;
  logic [IW-1:0]          pos_reg;
  logic [IW-1:0]          j_reg;
  logic [COUNT_WIDTH-1:0] cnt_reg;

  // scan stream: one read a cycle unless loading, data back next cycle
  logic [IW-1:0]          ptr;
  logic [OW-1:0]          left;
  logic                   dir_up;
  logic                   rd_vld;
  logic [IW-1:0]          rd_idx;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic                   issue;

  logic [IW-1:0]          ld_ptr;
  logic [OW-1:0]          ld_left;
  logic                   ld_up;

  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [KEY_WIDTH-1:0]   wr_key;
  logic [COUNT_WIDTH-1:0] wr_cnt;
  logic [31:0]            cnt_wide;

  assign issue   = (left != '0) && (cmd.load == LD_NONE);
  assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;

  always_comb begin
    ld_ptr  = '0;
    ld_left = '0;
    ld_up   = 1'b1;
    case (cmd.load)
      LD_FIND: begin
        ld_left = occ;
      end
      LD_ORDER: begin
        ld_left = OW'(rd_idx);
      end
      LD_SHUP: begin
        ld_ptr  = rd_idx + 1'b1;
        ld_left = occ - OW'(rd_idx) - OW'(1);
      end
      LD_SHDN: begin
        // rd_idx holds the first entry not above the new count
        ld_ptr  = pos_reg - 1'b1;
        ld_left = OW'(pos_reg) - OW'(rd_idx);
        ld_up   = 1'b0;
      end
      default: begin
        ld_up = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left   <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.load != LD_NONE) begin
      left   <= ld_left;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        left <= left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load != LD_NONE) begin
      ptr    <= ld_ptr;
      dir_up <= ld_up;
    end else if (issue) begin
      ptr    <= dir_up ? ptr + 1'b1 : ptr - 1'b1;
      rd_idx <= ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_key <= key_mem[ptr];
      rd_cnt <= cnt_mem[ptr];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_key  = rd_key;
    wr_cnt  = rd_cnt;
    case (cmd.wr)
      WR_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = IW'(occ);
        wr_key  = key_reg;
        wr_cnt  = '0;
      end
      WR_COUNT: begin
        wr_en  = 1'b1;
        wr_cnt = cnt_inc;
      end
      WR_SHDN: begin
        wr_en   = rd_vld;
        wr_addr = rd_idx + 1'b1;
      end
      WR_SHUP: begin
        wr_en   = rd_vld;
        wr_addr = rd_idx - 1'b1;
      end
      WR_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = j_reg;
        wr_key  = key_reg;
        wr_cnt  = cnt_reg;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      cnt_mem[wr_addr] <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_reg <= key_value;
    end
    if (cmd.latch_pos) begin
      pos_reg <= rd_idx;
      cnt_reg <= cnt_inc;
    end
    if (cmd.latch_j) begin
      j_reg <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.occ_inc) begin
      occ <= occ + 1'b1;
    end else if (cmd.occ_dec) begin
      occ <= occ - 1'b1;
    end
  end

  assign stat.full      = (occ == OW'(CAPACITY));
  assign stat.find_hit  = rd_vld && (rd_key == key_reg);
  assign stat.order_hit = rd_vld && (rd_cnt <= cnt_reg);
  assign stat.drained   = (left == '0) && !rd_vld;

  assign cnt_wide = 32'(cnt_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      status    <= cmd.rep_status;
      hit_count <= cmd.rep_count ? cnt_wide[HITS_WIDTH-1:0] : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(CAPACITY))
    else $error("occupancy above capacity");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (occ == $past(occ) || occ == $past(occ) + 1'b1 || occ + 1'b1 == $past(occ)))
    else $error("occupancy moved by more than one");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> stat.full)
    else $error("full reported while list has room");

  a_hits_ok: assert property (@(posedge clk) disable iff (rst)
    done && hit_count != '0 |-> status == ST_OK)
    else $error("nonzero count on a failed item");
`endif

endmodule

[hdl/count_ordered_self_organizing_list_unit.sv]
// top level of the count-ordered self-organizing list unit
// A list of up to CAPACITY keys with access counts, kept from highest count
// to lowest. An item is taken at a rising edge with start high and busy low:
// func selects insert at tail, delete first match or search, key_value is
// the key. Each item gives exactly one result, shown for one cycle with done
// high on status and hit_count; the receiver cannot stall, so it must take
// the result in that cycle. busy stays high while an item is in work and
// drops in the cycle its result is shown.
// The find scan, the order scan and the shift each walk the entries
// through the single memory read port at one read a cycle.
// One item is in work at a time. Reset empties the list (occupancy zero);
// entry memories need no clearing since only entries below the occupancy
// are ever read.
module count_ordered_self_organizing_list_unit #(
  parameter int CAPACITY    = cosol_pkg::DEF_CAPACITY,
  parameter int COUNT_WIDTH = cosol_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [cosol_pkg::FUNC_WIDTH-1:0]       func,
  input  logic signed [cosol_pkg::KEY_WIDTH-1:0] key_value,
  output logic                                   done,
  output logic [1:0]                             status,
  output logic [cosol_pkg::HITS_WIDTH-1:0]       hit_count
);
  import cosol_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  cosol_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  cosol_dp #(
    .CAPACITY    (CAPACITY),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .key_value (key_value),
    .stat      (stat),
    .done      (done),
    .status    (status),
    .hit_count (hit_count)
  );

endmodule
